>>> rtl/bbp_pkg.sv
// bbp_pkg: shared constants, types and helpers of the bimodal branch predictor
// no dependencies; every other file of the block imports it

package bbp_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int ADDR_BITS_DEF   = 32;

    localparam int TABLE_SIZE_W = 11;
    localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;

    localparam int CTR_W = 2;
    localparam logic [CTR_W-1:0] CTR_MAX         = 2'd3;
    localparam logic [CTR_W-1:0] TAKEN_THRESHOLD = 2'd2;

    localparam int COUNT_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_RESOLVE = 1'b0,
        OP_RESTART = 1'b1
    } bbp_op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_UPDATE,
        ST_DONE
    } bbp_state_t;

    // one saturating step of a 2-bit counter toward the outcome
    function automatic logic [CTR_W-1:0] ctr_step(input logic [CTR_W-1:0] ctr,
                                                  input logic taken);
        logic [CTR_W-1:0] res;
        res = ctr;
        if (taken)
        begin
            if (ctr != CTR_MAX)
                res = ctr + 1'b1;
        end
        else
        begin
            if (ctr != '0)
                res = ctr - 1'b1;
        end
        return res;
    endfunction

endpackage

>>> rtl/bbp_ifs.sv
// bbp_ifs: valid/ready channels of the predictor (branch items, results, table size)
// depends on bbp_pkg for widths

interface branch_if
    import bbp_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [ADDR_BITS-1:0] branch_address;
    logic                 taken;

    modport source (output valid, output mode, output branch_address, output taken,
                    input ready);
    modport sink   (input valid, input mode, input branch_address, input taken,
                    output ready);
endinterface

interface result_if
    import bbp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               predicted_taken;
    logic               was_correct;
    logic [COUNT_W-1:0] correct_total;

    modport source (output valid, output predicted_taken, output was_correct,
                    output correct_total, input ready);
    modport sink   (input valid, input predicted_taken, input was_correct,
                    input correct_total, output ready);
endinterface

interface cfg_if
    import bbp_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [TABLE_SIZE_W-1:0] table_size;

    modport source (output valid, output table_size, input ready);
    modport sink   (input valid, input table_size, output ready);
endinterface

>>> rtl/bbp_mod.sv
// bbp_mod: iterative restoring remainder unit, one address bit per cycle
// depends on bbp_pkg; used by bbp_back to form the table index

module bbp_mod
    import bbp_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [ADDR_BITS-1:0]    dividend,
    input  logic [TABLE_SIZE_W-1:0] divisor,
    output logic                    done,
    output logic [TABLE_SIZE_W-1:0] remainder
);

    localparam int CNT_W = $clog2(ADDR_BITS + 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [ADDR_BITS-1:0]    dvd_reg;
    logic [TABLE_SIZE_W-1:0] rem_reg;
    logic [TABLE_SIZE_W-1:0] rem_next;
    logic [TABLE_SIZE_W-1:0] div_reg;
    logic [TABLE_SIZE_W:0]   trial;
    logic [TABLE_SIZE_W:0]   diff;

    // remainder stays below the divisor, so trial is below twice the divisor
    assign trial = {rem_reg, dvd_reg[ADDR_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        if (trial >= {1'b0, div_reg})
            rem_next = diff[TABLE_SIZE_W-1:0];
        else
            rem_next = trial[TABLE_SIZE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ADDR_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ADDR_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/bbp_queue.sv
// bbp_queue: small register fifo between the front and the back of the predictor
// depends on bbp_pkg for the default depth

module bbp_queue
    import bbp_pkg::*;
#(
    parameter int WIDTH = ADDR_BITS_DEF + 2,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wptr_reg] <= wdata;
    end

endmodule

>>> rtl/bbp_front.sv
// bbp_front: accepts branch requests and table size writes, classifies requests
// depends on bbp_pkg and bbp_ifs; feeds bbp_queue

module bbp_front
    import bbp_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    branch_if.sink                  branch,
    cfg_if.sink                     cfg,
    input  logic                    init_busy,
    input  logic                    q_full,
    output logic                    q_push,
    output logic [ADDR_BITS+1:0]    q_wdata,
    output logic [TABLE_SIZE_W-1:0] eff_size
);

    logic [TABLE_SIZE_W-1:0] table_size_reg;
    bbp_op_t                 op;

    assign cfg.ready    = 1'b1;
    assign branch.ready = !q_full && !init_busy;
    assign q_push       = branch.valid && branch.ready;

    assign op      = branch.mode ? OP_RESTART : OP_RESOLVE;
    assign q_wdata = {op, branch.taken, branch.branch_address};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_size_reg <= TABLE_SIZE_RST;
        else if (cfg.valid && cfg.ready)
            table_size_reg <= cfg.table_size;
    end

    // zero acts as one, anything above the table depth saturates
    always_comb
    begin
        if (table_size_reg == '0)
            eff_size = TABLE_SIZE_W'(1);
        else if (32'(table_size_reg) > 32'(MAX_ENTRIES))
            eff_size = TABLE_SIZE_W'(MAX_ENTRIES);
        else
            eff_size = table_size_reg;
    end

endmodule

>>> rtl/bbp_back.sv
// bbp_back: counter table, index computation and result register of the predictor
// depends on bbp_pkg, bbp_ifs and bbp_mod; drains bbp_queue

module bbp_back
    import bbp_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [TABLE_SIZE_W-1:0] eff_size,
    input  logic                    q_empty,
    input  logic [ADDR_BITS+1:0]    q_rdata,
    output logic                    q_pop,
    output logic                    init_busy,
    result_if.source                result
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ENTRIES - 1);

    logic [CTR_W-1:0] mem [MAX_ENTRIES];

    bbp_state_t              state_reg;
    bbp_state_t              state_next;
    logic [IDX_W-1:0]        clr_reg;
    logic                    restart_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    taken_reg;
    logic [CTR_W-1:0]        rd_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic                    pred_reg;
    logic                    hit_reg;
    logic                    out_valid_reg;
    logic                    out_pred_reg;
    logic                    out_hit_reg;
    logic [COUNT_W-1:0]      out_total_reg;

    bbp_op_t                 q_op;
    logic                    q_taken;
    logic [ADDR_BITS-1:0]    q_addr;
    logic                    div_start;
    logic                    div_done;
    logic [TABLE_SIZE_W-1:0] div_rem;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [CTR_W-1:0]        mem_wdata;
    logic                    out_load;
    logic                    pred_now;
    logic                    hit_now;

    assign q_op    = bbp_op_t'(q_rdata[ADDR_BITS+1]);
    assign q_taken = q_rdata[ADDR_BITS];
    assign q_addr  = q_rdata[ADDR_BITS-1:0];

    bbp_mod #(
        .ADDR_BITS (ADDR_BITS)
    ) u_bbp_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (q_addr),
        .divisor   (eff_size),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign pred_now = (rd_reg >= TAKEN_THRESHOLD);
    assign hit_now  = (pred_now == taken_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == IDX_LAST)
                    state_next = restart_reg ? ST_DONE : ST_IDLE;
            end
            ST_IDLE:
            begin
                if (!q_empty)
                    state_next = (q_op == OP_RESTART) ? ST_CLEAR : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_READ;
            end
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = ctr_step(rd_reg, taken_reg);
        out_load  = 1'b0;
        init_busy = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = CTR_MAX;
                init_busy = !restart_reg;
            end
            ST_IDLE:
            begin
                q_pop     = !q_empty;
                div_start = !q_empty && (q_op == OP_RESOLVE);
            end
            ST_UPDATE:
            begin
                mem_we = 1'b1;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || result.ready;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            restart_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == IDX_LAST)
                    restart_reg <= 1'b0;
            end
            if (q_pop && (q_op == OP_RESTART))
            begin
                clr_reg     <= '0;
                restart_reg <= 1'b1;
                count_reg   <= '0;
            end
            if ((state_reg == ST_UPDATE) && hit_now && (count_reg != COUNT_MAX))
                count_reg <= count_reg + 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            taken_reg <= q_taken;
            pred_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        if ((state_reg == ST_DIV) && div_done)
            idx_reg <= IDX_W'(div_rem);
        if (state_reg == ST_UPDATE)
        begin
            pred_reg <= pred_now;
            hit_reg  <= hit_now;
        end
        if (out_load)
        begin
            out_pred_reg  <= pred_reg;
            out_hit_reg   <= hit_reg;
            out_total_reg <= count_reg;
        end
    end

    // counter table, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (state_reg == ST_READ)
            rd_reg <= mem[idx_reg];
    end

    assign result.valid           = out_valid_reg;
    assign result.predicted_taken = out_pred_reg;
    assign result.was_correct     = out_hit_reg;
    assign result.correct_total   = out_total_reg;

endmodule

>>> rtl/bimodal_branch_predictor_unit.sv
// bimodal_branch_predictor_unit: top level of the bimodal 2-bit counter predictor
// depends on bbp_pkg, bbp_ifs, bbp_front, bbp_queue, bbp_back
//
// usage:
//   branch: request with mode, branch_address and taken; mode 0 resolves a
//     branch, mode 1 restarts (all counters strongly taken, count cleared)
//   result: one item per request with predicted_taken, was_correct and the
//     running correct_total
//   cfg: table_size write; the user writes only while the block is idle, which
//     is not enforced; 0 acts as 1, above MAX_ENTRIES acts as MAX_ENTRIES
// operation: the back end handles one request at a time
//   a resolve forms the table index as the address modulo the effective
//   table_size, one address bit per cycle in the remainder unit, then does a
//   table read and a write back
//   a restart rewrites one counter per cycle
// reset: the table is swept to 3, one entry per cycle;
//   branch.ready stays low during that pass, cfg writes are taken as ever
// stalls: a two-entry queue keeps taking requests, until it is full, while a
//   result waits in the output register for result.ready

module bimodal_branch_predictor_unit
    import bbp_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    branch_if.sink    branch,
    result_if.source  result,
    cfg_if.sink       cfg
);

    localparam int Q_W = ADDR_BITS + 2;

    logic                    init_busy;
    logic                    q_full;
    logic                    q_empty;
    logic                    q_push;
    logic                    q_pop;
    logic [Q_W-1:0]          q_wdata;
    logic [Q_W-1:0]          q_rdata;
    logic [TABLE_SIZE_W-1:0] eff_size;

    bbp_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_bbp_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .branch    (branch),
        .cfg       (cfg),
        .init_busy (init_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata),
        .eff_size  (eff_size)
    );

    bbp_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_bbp_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    bbp_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_bbp_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_size  (eff_size),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .result    (result)
    );

endmodule

>>> rtl/bbp_checker.sv
// bbp_checker: port-level assertions for the predictor top level
// depends on bbp_pkg; bound to bimodal_branch_predictor_unit below

module bbp_checker
    import bbp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               predicted_taken,
    input logic               was_correct,
    input logic [COUNT_W-1:0] correct_total
);

    logic [3:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // requests taken but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (in_acc && !out_acc)
            pend_reg <= pend_reg + 1'b1;
        else if (out_acc && !in_acc)
            pend_reg <= pend_reg - 1'b1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(predicted_taken)
            && $stable(was_correct) && $stable(correct_total))
        else $error("result changed while stalled");

    a_correct_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_correct |-> correct_total != '0)
        else $error("correct result with zero total");

    a_init_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("request taken before table sweep");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result without pending request");

endmodule

bind bimodal_branch_predictor_unit bbp_checker u_bbp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (branch.valid),
    .in_ready        (branch.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .predicted_taken (result.predicted_taken),
    .was_correct     (result.was_correct),
    .correct_total   (result.correct_total)
);
